/* src/gadr_pkg.sv */
package gadr_pkg;

  localparam int DELAY_DEPTH        = 32768;
  localparam int TANH_TABLE_ENTRIES = 256;

  localparam int TANH_LOG2 = $clog2(TANH_TABLE_ENTRIES);
  localparam int TIDX_W    = TANH_LOG2 + 1;
  localparam int FRAC_W    = 16;
  localparam int FRAC_LSB  = 21 - TANH_LOG2;
  localparam int IDX_LSB   = FRAC_LSB + FRAC_W;
  localparam int BIG_LSB   = IDX_LSB + TANH_LOG2;

  localparam int PTR_W = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int HWM_W = $clog2(DELAY_DEPTH + 1);

  localparam int SAMPLE_W  = 24;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int FB_W      = 15;
  localparam int LEN_W     = (HWM_W > CFG_W) ? HWM_W : CFG_W;
  localparam int GAIN5_W   = 19;

  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 20;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;

  localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] SAT_LO  = -ACC_W'(8388608);
  localparam logic signed [ACC_W-1:0] ROUND15 = ACC_W'(16384);

  localparam logic signed [MUL_B_W-1:0] K_NEW   = MUL_B_W'(26214);
  localparam logic signed [MUL_B_W-1:0] K_OLD   = MUL_B_W'(6554);
  localparam logic signed [MUL_B_W-1:0] K_UNITY = MUL_B_W'(32768);

  localparam logic [CFG_W-1:0] PRE_GAIN_RST = CFG_W'(40960);
  localparam logic [CFG_W-1:0] MASTER_RST   = CFG_W'(16384);
  localparam logic [CFG_W-1:0] WET_RST      = CFG_W'(6554);
  localparam logic [FB_W-1:0]  FB_RST       = FB_W'(21299);
  localparam logic [CFG_W-1:0] LEN_RST      = CFG_W'(24000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRE_GAIN      = 3'd0,
    REG_MASTER_LEVEL  = 3'd1,
    REG_WET_MIX       = 3'd2,
    REG_ECHO_FEEDBACK = 3'd3,
    REG_DELAY_LENGTH  = 3'd4
  } cfg_reg_e;

  typedef logic [TANH_TABLE_ENTRIES:0][SAMPLE_W-1:0] tanh_tab_t;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  function automatic logic [63:0] udiv64(input logic [63:0] dividend,
                                         input logic [63:0] divisor);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], dividend[b]};
      if (rem >= {1'b0, divisor}) begin
        rem    = rem - {1'b0, divisor};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
    logic [63:0] term;
    logic [63:0] sum;
    term = Q30_ONE;
    sum  = Q30_ONE;
    for (int k = 1; k <= 24; k++) begin
      term = udiv64((term * f) >> 30, 64'(k));
      sum  = sum + term;
    end
    return udiv64((Q30_ONE << 30) + (sum >> 1), sum);
  endfunction

  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t   tab;
    logic [63:0] em1;
    logic [63:0] w;
    logic [63:0] n;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] t;
    em1 = exp_neg_q30(Q30_ONE);
    for (int i = 0; i <= TANH_TABLE_ENTRIES; i++) begin
      w = (64'(i) << 34) >> TANH_LOG2;
      n = w >> 30;
      e = exp_neg_q30(w & (Q30_ONE - 64'd1));
      for (int j = 0; j < 16; j++) begin
        if (64'(j) < n) begin
          e = (e * em1 + (Q30_ONE >> 1)) >> 30;
        end
      end
      if (e > Q30_ONE) begin
        e = Q30_ONE;
      end
      num = (Q30_ONE - e) << 23;
      den = Q30_ONE + e;
      t   = udiv64(num + (den >> 1), den);
      if (t > 64'd8388607) begin
        t = 64'd8388607;
      end
      tab[i] = t[SAMPLE_W-1:0];
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = v;
    end
    return r[SAMPLE_W-1:0];
  endfunction

endpackage

/* src/guitar_amp_distortion_reverb_top.sv */
// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_ready_o  sample_in_i, input_missing_i, frame_end_i
// output    out        out_valid_o/ out_ready_i sample_out_o, frame_end_out_o
// config    in         cfg_we_i (no wait)       cfg_idx_i, cfg_wdata_i
//
// An item passes through the sequencer steps from acceptance to a loaded output register,
// paced by the single 25x20 multiplier that serves all eight products in turn; a missing
// item goes straight from idle to the mix step. in_ready_o is high only while the sequencer
// is idle, so a new item is taken only once the last is in the output register, which holds
// one item. A stalled output holds the sequencer in its last step until the item is taken.
// Reset clears control state; the echo store is tracked by a fill count, so no clearing pass.
module guitar_amp_distortion_reverb_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [gadr_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic                                 input_missing_i,
  input  logic                                 frame_end_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [gadr_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                 frame_end_out_o,
  input  logic                                 cfg_we_i,
  input  logic [gadr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [gadr_pkg::CFG_W-1:0]           cfg_wdata_i
);
  import gadr_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'h0001,
    S_GAIN   = 13'h0002,
    S_IDX    = 13'h0004,
    S_INTERP = 13'h0008,
    S_CLIP   = 13'h0010,
    S_SM1    = 13'h0020,
    S_SM2    = 13'h0040,
    S_SM3    = 13'h0080,
    S_MST    = 13'h0100,
    S_LEVEL  = 13'h0200,
    S_ECHO   = 13'h0400,
    S_DRY    = 13'h0800,
    S_MIX    = 13'h1000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0] pre_gain_q, master_q, wet_q, len_q;
  logic [FB_W-1:0]  fb_q;

  logic [SAMPLE_W-1:0]        mag_q, mag_d;
  logic                       sign_q, sign_d;
  logic                       zero_q, zero_d;
  logic                       fe_q, fe_d;
  logic signed [SAMPLE_W-1:0] old_q, old_d;
  logic [SAMPLE_W-1:0]        lo_q, lo_d;
  logic signed [MUL_A_W-1:0]  dlt_q, dlt_d;
  logic [FRAC_W-1:0]          frac_q, frac_d;
  logic signed [SAMPLE_W-1:0] y_q, y_d;
  logic signed [SAMPLE_W-1:0] s_q, s_d;
  logic signed [SAMPLE_W-1:0] prev_q, prev_d;
  logic signed [SAMPLE_W-1:0] m_q, m_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic [PTR_W-1:0]           ptr_q, ptr_d;
  logic [HWM_W-1:0]           hwm_q, hwm_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_sample_q, out_sample_d;
  logic                       out_fe_q, out_fe_d;

  logic signed [PROD_W-1:0]  mul_q;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [ACC_W-1:0]   mul_x;

  logic signed [SAMPLE_W-1:0] echo_mem [DELAY_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_q;
  logic                       mem_we;
  logic signed [SAMPLE_W-1:0] mem_wdata;

  logic [GAIN5_W-1:0]        gain5;
  logic signed [MUL_B_W-1:0] dry_w;
  logic                      old_ok;
  logic                      big;
  logic [TANH_LOG2-1:0]      idx;
  logic [TIDX_W-1:0]         lo_idx, hi_idx;
  logic signed [ACC_W-1:0]   clip_sum, echo_base;
  logic [HWM_W-1:0]          ptr_nxt;
  logic                      wrap;

  assign mul_x     = ACC_W'(mul_q);
  assign gain5     = GAIN5_W'({pre_gain_q, 2'b00}) + GAIN5_W'(pre_gain_q);
  assign dry_w     = K_UNITY - $signed(MUL_B_W'(wet_q));
  assign old_ok    = HWM_W'(ptr_q) < hwm_q;
  assign big       = |mul_q[PROD_W-1:BIG_LSB];
  assign idx       = mul_q[IDX_LSB +: TANH_LOG2];
  assign lo_idx    = big ? TIDX_W'(TANH_TABLE_ENTRIES) : TIDX_W'(idx);
  assign hi_idx    = TIDX_W'(idx) + 1'b1;
  assign clip_sum  = (acc_q + mul_x) >>> FRAC_W;
  assign echo_base = {{(ACC_W - SAMPLE_W - 15){m_q[SAMPLE_W-1]}}, m_q, 15'h4000};
  assign ptr_nxt   = HWM_W'(ptr_q) + 1'b1;
  assign wrap      = (LEN_W'(ptr_nxt) >= LEN_W'(len_q)) || (ptr_nxt == HWM_W'(DELAY_DEPTH));

  always_comb begin
    state_d      = state_q;
    mag_d        = mag_q;
    sign_d       = sign_q;
    zero_d       = zero_q;
    fe_d         = fe_q;
    old_d        = old_q;
    lo_d         = lo_q;
    dlt_d        = dlt_q;
    frac_d       = frac_q;
    y_d          = y_q;
    s_d          = s_q;
    prev_d       = prev_q;
    m_d          = m_q;
    acc_d        = acc_q;
    ptr_d        = ptr_q;
    hwm_d        = hwm_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_sample_d = out_sample_q;
    out_fe_d     = out_fe_q;
    mem_we       = 1'b0;
    mem_wdata    = sat24((echo_base + mul_x) >>> 15);
    mul_a        = '0;
    mul_b        = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          fe_d    = frame_end_i;
          sign_d  = sample_in_i[SAMPLE_W-1];
          mag_d   = sample_in_i[SAMPLE_W-1] ? SAMPLE_W'(-sample_in_i) : sample_in_i;
          zero_d  = input_missing_i;
          state_d = input_missing_i ? S_MIX : S_GAIN;
        end
      end
      S_GAIN: begin
        mul_a   = $signed(MUL_A_W'(mag_q));
        mul_b   = $signed(MUL_B_W'(gain5));
        old_d   = old_ok ? rd_q : '0;
        state_d = S_IDX;
      end
      S_IDX: begin
        lo_d    = TANH_TAB[lo_idx];
        dlt_d   = big ? '0 : $signed(MUL_A_W'(TANH_TAB[hi_idx]))
                             - $signed(MUL_A_W'(TANH_TAB[lo_idx]));
        frac_d  = mul_q[FRAC_LSB +: FRAC_W];
        state_d = S_INTERP;
      end
      S_INTERP: begin
        mul_a   = dlt_q;
        mul_b   = $signed(MUL_B_W'(frac_q));
        acc_d   = $signed(ACC_W'({lo_q, dlt_q[MUL_A_W-1] ? 16'hFFFF : 16'h0000}));
        state_d = S_CLIP;
      end
      S_CLIP: begin
        if (clip_sum > SAT_HI) begin
          y_d = SAT_HI[SAMPLE_W-1:0];
        end else if (clip_sum < 0) begin
          y_d = '0;
        end else begin
          y_d = clip_sum[SAMPLE_W-1:0];
        end
        if (sign_q) begin
          y_d = -y_d;
        end
        state_d = S_SM1;
      end
      S_SM1: begin
        mul_a   = MUL_A_W'(y_q);
        mul_b   = K_NEW;
        state_d = S_SM2;
      end
      S_SM2: begin
        mul_a   = MUL_A_W'(prev_q);
        mul_b   = K_OLD;
        acc_d   = mul_x + ROUND15;
        state_d = S_SM3;
      end
      S_SM3: begin
        s_d     = sat24((acc_q + mul_x) >>> 15);
        prev_d  = s_d;
        state_d = S_MST;
      end
      S_MST: begin
        mul_a   = MUL_A_W'(s_q);
        mul_b   = $signed(MUL_B_W'(master_q));
        state_d = S_LEVEL;
      end
      S_LEVEL: begin
        m_d     = sat24((mul_x + ROUND15) >>> 15);
        mul_a   = MUL_A_W'(old_q);
        mul_b   = $signed(MUL_B_W'(fb_q));
        state_d = S_ECHO;
      end
      S_ECHO: begin
        mem_we = 1'b1;
        ptr_d  = wrap ? '0 : ptr_nxt[PTR_W-1:0];
        if (HWM_W'(ptr_q) == hwm_q) begin
          hwm_d = hwm_q + 1'b1;
        end
        mul_a   = MUL_A_W'(m_q);
        mul_b   = dry_w;
        state_d = S_DRY;
      end
      S_DRY: begin
        acc_d   = mul_x + ROUND15;
        mul_a   = MUL_A_W'(old_q);
        mul_b   = $signed(MUL_B_W'(wet_q));
        state_d = S_MIX;
      end
      S_MIX: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_sample_d = zero_q ? '0 : sat24((acc_q + mul_x) >>> 15);
          out_fe_d     = fe_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_q      <= '0;
      ptr_q       <= '0;
      hwm_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      ptr_q       <= ptr_d;
      hwm_q       <= hwm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_gain_q <= PRE_GAIN_RST;
      master_q   <= MASTER_RST;
      wet_q      <= WET_RST;
      fb_q       <= FB_RST;
      len_q      <= LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PRE_GAIN:      pre_gain_q <= cfg_wdata_i;
        REG_MASTER_LEVEL:  master_q   <= cfg_wdata_i;
        REG_WET_MIX:       wet_q      <= cfg_wdata_i;
        REG_ECHO_FEEDBACK: fb_q       <= cfg_wdata_i[FB_W-1:0];
        REG_DELAY_LENGTH:  len_q      <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q        <= mag_d;
    sign_q       <= sign_d;
    zero_q       <= zero_d;
    fe_q         <= fe_d;
    old_q        <= old_d;
    lo_q         <= lo_d;
    dlt_q        <= dlt_d;
    frac_q       <= frac_d;
    y_q          <= y_d;
    s_q          <= s_d;
    m_q          <= m_d;
    acc_q        <= acc_d;
    out_sample_q <= out_sample_d;
    out_fe_q     <= out_fe_d;
    if (state_q != S_MIX) begin
      mul_q <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      echo_mem[ptr_q] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= echo_mem[ptr_q];
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = out_sample_q;
  assign frame_end_out_o = out_fe_q;

  a_ptr_within_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    HWM_W'(ptr_q) <= hwm_q)
    else $error("write pointer beyond filled part of echo store");

  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hwm_q <= HWM_W'(DELAY_DEPTH))
    else $error("fill count beyond echo store depth");

  a_missing_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && input_missing_i) |=> (state_q == S_MIX))
    else $error("missing item entered the datapath");

  a_fill_covers_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ECHO) |=> (hwm_q > HWM_W'($past(ptr_q))))
    else $error("written echo entry not covered by fill count");

endmodule
